// File: hw/rtl/sha256_pkg.sv
// SHA-256 message hasher: shared types, constants and round functions.
// No dependencies.
package sha256_pkg;

  localparam logic [31:0] RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] InitH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [7:0] PadByte = 8'h80;

  // Queue entry between front and back: one byte, or end-of-message marker.
  typedef struct packed {
    logic [7:0] data;
    logic       present;
    logic       last;
  } byte_cmd_t;

  function automatic logic [31:0] rotr(input logic [31:0] v, input int n);
    rotr = (v >> n) | (v << (32 - n));
  endfunction

  function automatic logic [31:0] bsig0(input logic [31:0] v);
    bsig0 = rotr(v, 2) ^ rotr(v, 13) ^ rotr(v, 22);
  endfunction
  function automatic logic [31:0] bsig1(input logic [31:0] v);
    bsig1 = rotr(v, 6) ^ rotr(v, 11) ^ rotr(v, 25);
  endfunction
  function automatic logic [31:0] ssig0(input logic [31:0] v);
    ssig0 = rotr(v, 7) ^ rotr(v, 18) ^ (v >> 3);
  endfunction
  function automatic logic [31:0] ssig1(input logic [31:0] v);
    ssig1 = rotr(v, 17) ^ rotr(v, 19) ^ (v >> 10);
  endfunction

endpackage

// File: hw/rtl/sha256_if.sv
// Valid/ready channel interfaces for the hasher.
// Depends on nothing.
interface sha256_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_present;
  logic       last_byte;
  modport source (output valid, data_byte, byte_present, last_byte, input ready);
  modport sink (input valid, data_byte, byte_present, last_byte, output ready);
endinterface

interface sha256_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;
  modport source (output valid, digest_word, word_index, last_word, input ready);
  modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface

// File: hw/rtl/sha256_front.sv
// Front end: accepts input transactions, drops empty non-last items,
// and pushes commands into a 4-entry queue. Depends on sha256_pkg.
module sha256_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  sha256_in_if.sink             in_ch,
  output logic                  cmd_valid_o,
  output sha256_pkg::byte_cmd_t cmd_o,
  input  logic                  cmd_ready_i
);
  sha256_pkg::byte_cmd_t fifo_q [4];
  logic [1:0] wr_q, rd_q;
  logic [2:0] cnt_q;
  logic push, pop;

  assign in_ch.ready = (cnt_q != 3'd4);
  assign push = in_ch.valid && in_ch.ready && (in_ch.byte_present || in_ch.last_byte);
  assign cmd_valid_o = (cnt_q != 3'd0);
  assign pop = cmd_valid_o && cmd_ready_i;
  assign cmd_o = fifo_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_q] <= '{data: in_ch.data_byte, present: in_ch.byte_present,
                        last: in_ch.last_byte};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wr_q <= wr_q + 2'd1;
      if (pop) rd_q <= rd_q + 2'd1;
      cnt_q <= cnt_q + {2'd0, push} - {2'd0, pop};
    end
  end
endmodule

// File: hw/rtl/sha256_back.sv
// Back end: packs bytes, pads, runs one compression round per cycle and
// streams the digest. Depends on sha256_pkg and sha256_if.
module sha256_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cmd_valid_i,
  input  sha256_pkg::byte_cmd_t cmd_i,
  output logic                  cmd_ready_o,
  sha256_out_if.source          out_ch
);
  localparam logic [2:0] StIdle = 3'd0, StPad = 3'd1, StLen = 3'd2,
                         StComp = 3'd3, StAdd = 3'd4, StOut = 3'd5;

  logic [2:0]  st_q, st_d;
  logic [31:0] blk_q [16];
  logic [31:0] w_q [16];
  logic [31:0] v_q [8];
  logic [31:0] h_q [8];
  logic [63:0] bits_q, len_q;
  logic [5:0]  pos_q;
  logic [5:0]  rnd_q;
  logic [2:0]  oidx_q;
  logic        fin_q;     // compression belongs to end-of-message padding
  logic [2:0]  ret_q;     // state to resume after compression

  logic        put;
  logic [7:0]  pbyte;
  logic [31:0] wnew, t1, t2;
  logic        full;

  always_comb begin
    put = 1'b0;
    pbyte = 8'd0;
    case (st_q)
      StIdle: begin
        if (cmd_valid_i && cmd_i.present) begin
          put = 1'b1;
          pbyte = cmd_i.data;
        end
      end
      StPad: begin
        put = 1'b1;
        pbyte = fin_q ? 8'd0 : sha256_pkg::PadByte;
      end
      StLen: begin
        put = 1'b1;
        pbyte = len_q[63:56];
      end
      default: ;
    endcase
  end

  // A command is taken whenever the back end is in Idle.
  assign cmd_ready_o = (st_q == StIdle);

  // Byte at pos 63 finishes the block; it is forwarded into the window load.
  assign full = put && (pos_q == 6'd63);

  always_comb begin
    wnew = (rnd_q < 6'd16) ? w_q[0]
         : sha256_pkg::ssig1(w_q[14]) + w_q[9] + sha256_pkg::ssig0(w_q[1]) + w_q[0];
    t1 = v_q[7] + sha256_pkg::bsig1(v_q[4]) + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]))
       + sha256_pkg::RoundK[rnd_q] + wnew;
    t2 = sha256_pkg::bsig0(v_q[0])
       + ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
  end

  assign out_ch.valid = (st_q == StOut);
  assign out_ch.digest_word = h_q[oidx_q];
  assign out_ch.word_index = oidx_q;
  assign out_ch.last_word = (oidx_q == 3'd7);

  always_ff @(posedge clk_i) begin
    if (put) begin
      if (pos_q[1:0] == 2'd0) begin
        blk_q[pos_q[5:2]] <= {pbyte, 24'd0};
      end else begin
        blk_q[pos_q[5:2]] <= blk_q[pos_q[5:2]] | ({24'd0, pbyte} << {~pos_q[1:0], 3'd0});
      end
    end
    if (st_q == StComp) begin
      // window kept shifted: w_q[0] is the word of this round
      for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
      w_q[15] <= wnew;
      v_q[7] <= v_q[6]; v_q[6] <= v_q[5]; v_q[5] <= v_q[4];
      v_q[4] <= v_q[3] + t1;
      v_q[3] <= v_q[2]; v_q[2] <= v_q[1]; v_q[1] <= v_q[0];
      v_q[0] <= t1 + t2;
    end else begin
      for (int i = 0; i < 15; i++) w_q[i] <= blk_q[i];
      // last byte of the block is written on this same edge
      w_q[15] <= full ? (blk_q[15] | {24'd0, pbyte}) : blk_q[15];
      v_q <= h_q;
    end
    if (st_q == StLen) len_q <= {len_q[55:0], 8'd0};
    else if (st_q == StIdle) len_q <= bits_q + (cmd_i.present ? 64'd8 : 64'd0);
  end

  always_comb begin
    st_d = st_q;
    case (st_q)
      StIdle: if (cmd_valid_i) begin
        if (full) st_d = StComp;
        else if (cmd_i.last) st_d = StPad;
      end
      StPad: if (full) st_d = StComp;
        else if (pos_q == 6'd55) st_d = StLen;
      StLen: if (full) st_d = StComp;
      StComp: if (rnd_q == 6'd63) st_d = StAdd;
      StAdd: st_d = ret_q;
      StOut: if (out_ch.ready && oidx_q == 3'd7) st_d = StIdle;
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle;
      h_q <= sha256_pkg::InitH;
      bits_q <= '0;
      pos_q <= '0;
      rnd_q <= '0;
      oidx_q <= '0;
      fin_q <= 1'b0;
      ret_q <= StIdle;
    end else begin
      st_q <= st_d;
      if (put) pos_q <= pos_q + 6'd1;
      if (st_q == StIdle && cmd_valid_i && cmd_i.present) bits_q <= bits_q + 64'd8;
      if (st_q == StIdle && cmd_valid_i) begin
        fin_q <= 1'b0;
        ret_q <= cmd_i.last ? StPad : StIdle;
      end
      if (st_q == StPad) begin
        fin_q <= 1'b1;
        if (full) ret_q <= StPad;
      end
      if (st_q == StLen) begin
        if (full) ret_q <= StOut;
      end
      if (st_q == StComp) rnd_q <= rnd_q + 6'd1;
      else rnd_q <= '0;
      if (st_q == StAdd) begin
        for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
      end
      if (st_q == StOut && out_ch.ready) begin
        oidx_q <= oidx_q + 3'd1;
        if (oidx_q == 3'd7) begin
          h_q <= sha256_pkg::InitH;
          bits_q <= '0;
          pos_q <= '0;
        end
      end
    end
  end
endmodule

// File: hw/rtl/sha256_message_hasher.sv
// SHA-256 message hasher top level: front queue plus compression back end.
// Depends on sha256_pkg, sha256_if, sha256_front, sha256_back.
//
// Usage: in_ch carries one byte per transaction (byte_present), last_byte ends
// the message; a last with no byte ends it as it stands (empty message works).
// Items with neither flag are dropped. out_ch then gives eight 32-bit digest
// words, index 0 (most significant) first, last_word on index 7.
// Throughput: the back end takes one byte per cycle while it is in Idle; it
// takes no byte while a full 64-byte block goes through the single shared
// round unit and the chaining step that follows it. The end of a message adds
// the pad and length bytes and one or two compressions, then eight output
// transactions.
// A 4-entry queue between front and back lets input keep flowing while the
// back end compresses; when it fills, in_ch.ready drops.
// Reset (rst_ni low, asynchronous) empties the queue, restores the initial
// hash values and clears bit count and byte position.
// A stalled receiver holds the current digest word; no input is consumed by
// the back end until all eight words are taken.
module sha256_message_hasher (
  input  logic          clk_i,
  input  logic          rst_ni,
  sha256_in_if.sink     in_ch,
  sha256_out_if.source  out_ch
);
  logic                  cmd_valid, cmd_ready;
  sha256_pkg::byte_cmd_t cmd;

  sha256_front u_front (
    .clk_i, .rst_ni, .in_ch,
    .cmd_valid_o(cmd_valid), .cmd_o(cmd), .cmd_ready_i(cmd_ready)
  );

  sha256_back u_back (
    .clk_i, .rst_ni,
    .cmd_valid_i(cmd_valid), .cmd_i(cmd), .cmd_ready_o(cmd_ready),
    .out_ch
  );
endmodule
